[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srle assertion failed");

`endif

[hw/rtl/srle_pkg.sv]
// Types and constants of the sprite skip/copy run-length decoder.
// Used by every module of the block but srle_div; depends on nothing.
`default_nettype none

package srle_pkg;

    localparam int BYTE_W      = 8;
    localparam int PIX_X_W     = 10;
    localparam int PIX_Y_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR     = 2'd3;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERRUN  = 2'd3;

    // Sticky fault codes share their values with the status codes.
    localparam logic [STATUS_W-1:0] FAULT_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] FAULT_ZERO_LEN = ST_ZERO_LEN;
    localparam logic [STATUS_W-1:0] FAULT_OVERRUN  = ST_OVERRUN;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_CHUNK,
        PH_COPY
    } t_phase;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DIV,
        BK_END,
        BK_ISSUE
    } t_bk_state;

    // One queued request, classified on entry.
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] data;
        logic              zero;
    } t_item;

    // Mode bits and the write strobe handed from the register file.
    typedef struct packed {
        logic compressed;
        logic mirror;
        logic cfg_wr;
    } t_mode;

    typedef struct packed {
        logic                pixel_valid;
        logic [PIX_X_W-1:0]  pixel_x;
        logic [PIX_Y_W-1:0]  pixel_y;
        logic [BYTE_W-1:0]   pixel_value;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/sprite_skip_copy_rle_decoder.sv]
// Top level of the sprite skip/copy run-length decoder: configuration
// registers, image size, and the front and back ends. Depends on srle_pkg.
//
//   Channel   Direction  Handshake                 Carries
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in        in         i_in_valid / o_in_ready    i_start_image, i_data_byte
//   out       out        o_out_valid / i_out_ready  o_pixel_*, o_status
//
// A byte that ends a line passes through an end state before its result is issued.
// A skip that carries the position over more than one row runs the shared
// one-bit-per-cycle divider over the PW-bit position, PW being the position
// width (21 bits at the default size). Every configuration write starts the
// same divider to rebuild row and column before the next byte is taken.
// Reset is synchronous and needs no clearing pass. A two-entry queue lets the
// front accept bytes while the back end waits on a stalled output register.
`default_nettype none

module sprite_skip_copy_rle_decoder #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [srle_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [srle_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_start_image,
    input  wire logic [7:0]                            i_data_byte,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_pixel_valid,
    output logic [9:0]                                 o_pixel_x,
    output logic [9:0]                                 o_pixel_y,
    output logic [7:0]                                 o_pixel_value,
    output logic [1:0]                                 o_status
);
    import srle_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 256);

    logic [CFG_DATA_W-1:0] r_image_width;
    logic [CFG_DATA_W-1:0] r_image_height;
    logic                  r_compressed;
    logic                  r_mirror;
    logic [PW-1:0]         r_count;
    logic                  cfg_wr;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    t_mode                 mode;
    logic                  item_valid;
    t_item                 item;
    logic                  pop;
    t_result               out;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_DATA_W'(1);
            r_image_height <= CFG_DATA_W'(1);
            r_compressed   <= 1'b1;
            r_mirror       <= 1'b0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_WIDTH:      r_image_width  <= i_cfg_data;
                CFG_HEIGHT:     r_image_height <= i_cfg_data;
                CFG_COMPRESSED: r_compressed   <= i_cfg_data[0];
                CFG_MIRROR:     r_mirror       <= i_cfg_data[0];
                default:        r_mirror       <= r_mirror;
            endcase
        end
    end

    // A zero size counts as one; a size above the maximum is clipped.
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_image_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= PW'(1);
        end else begin
            r_count <= PW'(w_eff) * PW'(h_eff);
        end
    end

    always_comb begin
        mode.compressed = r_compressed;
        mode.mirror     = r_mirror;
        mode.cfg_wr     = cfg_wr;
    end

    srle_front u_srle_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_start_image (i_start_image),
        .i_data_byte   (i_data_byte),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_pop         (pop)
    );

    srle_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_srle_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .i_mode       (mode),
        .i_w_eff      (w_eff),
        .i_count      (r_count),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out        (out)
    );

    assign o_pixel_valid = out.pixel_valid;
    assign o_pixel_x     = out.pixel_x;
    assign o_pixel_y     = out.pixel_y;
    assign o_pixel_value = out.pixel_value;
    assign o_status      = out.status;

endmodule

`default_nettype wire

[hw/rtl/srle_front.sv]
// Front end: accepts input requests, classifies them and queues them.
// Depends on srle_pkg.
`default_nettype none

module srle_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_start_image,
    input  wire logic [7:0]              i_data_byte,
    output logic                         o_item_valid,
    output srle_pkg::t_item              o_item,
    input  wire logic                    i_pop
);
    import srle_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_fill;
    logic                   push;
    logic                   pop;
    t_item                  new_item;

    assign o_in_ready   = (r_fill != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_fill != '0);
    assign push         = i_in_valid & o_in_ready;
    assign pop          = i_pop & o_item_valid;

    always_comb begin
        new_item.start = i_start_image;
        new_item.data  = i_data_byte;
        new_item.zero  = (i_data_byte == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    assign o_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/srle_div.sv]
// Restoring divider, one quotient bit per cycle, for turning a write
// position into row and column. Self-contained; depends on no other file.
`default_nettype none

module srle_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient,
    output logic [DIVISOR_W-1:0]       o_remainder
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[hw/rtl/srle_back.sv]
// Back end: line/skip/copy sequencer, position tracking and result register.
// Depends on srle_pkg and srle_div.
`default_nettype none

module srle_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                                            i_clk,
    input  wire logic                                            i_rst_n,
    input  wire logic                                            i_item_valid,
    input  wire srle_pkg::t_item                                 i_item,
    output logic                                                 o_pop,
    input  wire srle_pkg::t_mode                                 i_mode,
    input  wire logic [$clog2(MAX_WIDTH + 1)-1:0]                i_w_eff,
    input  wire logic [$clog2(MAX_WIDTH * MAX_HEIGHT + 256)-1:0] i_count,
    input  wire logic                                            i_out_ready,
    output logic                                                 o_out_valid,
    output srle_pkg::t_result                                    o_out
);
    import srle_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 256);
    localparam int AW = PW + 1;

    t_bk_state         r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [7:0]        r_line_left, n_line_left;
    logic              r_next_skip, n_next_skip;
    logic [7:0]        r_copy_left, n_copy_left;
    logic [PW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_col, n_col;
    logic [PW-1:0]     r_row, n_row;
    logic              r_finished, n_finished;
    logic [STATUS_W-1:0] r_fault, n_fault;
    logic              r_recalc, n_recalc;
    t_result           r_pend, n_pend;
    logic              r_pend_end, n_pend_end;
    logic              r_pend_issue, n_pend_issue;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    // Decoder state as seen by this request, after an optional restart.
    logic              start;
    t_phase            c_phase;
    logic [7:0]        c_line_left;
    logic              c_next_skip;
    logic [7:0]        c_copy_left;
    logic [PW-1:0]     c_pos;
    logic [CW-1:0]     c_col;
    logic [PW-1:0]     c_row;
    logic              c_finished;
    logic [STATUS_W-1:0] c_fault;

    logic [7:0]        b;
    logic [PW-1:0]     b_pos;
    logic              out_free;
    logic [PW-1:0]     room;
    logic              in_image;
    logic [PW-1:0]     pos_inc;
    logic [AW-1:0]     col_p1;
    logic              col_wrap;
    logic [CW-1:0]     col_nxt;
    logic [PW-1:0]     row_nxt;
    logic              raw_done;
    logic [7:0]        ll_dec;
    logic [7:0]        cl_dec;
    logic [PW-1:0]     sat_pos;
    logic [PW-1:0]     skip_pos;
    logic [AW-1:0]     skip_sum;
    logic [AW-1:0]     skip_sum_w;
    logic              skip_fast;
    logic              skip_one_row;
    logic              copy_over;
    logic [AW-1:0]     mirror_x;
    t_result           emit_res;
    logic              end_pad;
    logic [PW-1:0]     end_pos;
    logic              end_done;

    logic              div_start;
    logic [PW-1:0]     div_dividend;
    logic              div_done;
    logic [PW-1:0]     div_quo;
    logic [WW-1:0]     div_rem;

    logic              issue;
    t_result           pix;

    function automatic logic [STATUS_W-1:0] status_of(input logic [STATUS_W-1:0] fault,
                                                      input logic finished);
        logic [STATUS_W-1:0] st;
        if (fault != FAULT_NONE) begin
            st = fault;
        end else if (finished) begin
            st = ST_DONE;
        end else begin
            st = ST_BUSY;
        end
        return st;
    endfunction

    srle_div #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (WW)
    ) u_srle_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (i_w_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign start       = i_item.start;
    assign c_phase     = start ? PH_LEN : r_phase;
    assign c_line_left = start ? 8'd0 : r_line_left;
    assign c_next_skip = start ? 1'b1 : r_next_skip;
    assign c_copy_left = start ? 8'd0 : r_copy_left;
    assign c_pos       = start ? '0 : r_pos;
    assign c_col       = start ? '0 : r_col;
    assign c_row       = start ? '0 : r_row;
    assign c_finished  = start ? 1'b0 : r_finished;
    assign c_fault     = start ? FAULT_NONE : r_fault;

    assign b        = i_item.data;
    assign b_pos    = PW'(b);
    assign out_free = !r_out_valid || i_out_ready;

    assign in_image = (c_pos < i_count);
    assign room     = in_image ? (i_count - c_pos) : '0;

    // Single step forward, wrapping the column at the row end.
    assign pos_inc  = c_pos + 1'b1;
    assign col_p1   = AW'(c_col) + AW'(1);
    assign col_wrap = (col_p1 == AW'(i_w_eff));
    assign col_nxt  = col_wrap ? '0 : CW'(col_p1);
    assign row_nxt  = col_wrap ? (c_row + 1'b1) : c_row;
    assign raw_done = in_image ? (pos_inc >= i_count) : 1'b1;

    assign ll_dec = c_line_left - 1'b1;
    assign cl_dec = c_copy_left - 1'b1;

    // A skip saturates at the image end. The step is at most one byte, so
    // a column carry of up to one row is settled here; more goes to the divider.
    assign sat_pos      = (c_pos > i_count) ? c_pos : i_count;
    assign skip_pos     = (b_pos >= room) ? sat_pos : (c_pos + b_pos);
    assign skip_sum     = AW'(c_col) + AW'(skip_pos - c_pos);
    assign skip_sum_w   = skip_sum - AW'(i_w_eff);
    assign skip_fast    = (skip_sum < AW'(i_w_eff));
    assign skip_one_row = (skip_sum_w < AW'(i_w_eff));

    assign copy_over = (b_pos > room) || (b > ll_dec);

    assign mirror_x = AW'(i_w_eff) - AW'(c_col) - AW'(1);

    always_comb begin
        emit_res.pixel_valid = 1'b1;
        emit_res.pixel_x     = i_mode.mirror ? PIX_X_W'(mirror_x) : PIX_X_W'(c_col);
        emit_res.pixel_y     = PIX_Y_W'(c_row);
        emit_res.pixel_value = b;
        emit_res.status      = ST_BUSY;
    end

    // Padding to the next row at the end of a line.
    assign end_pad  = (r_pos < i_count) && (r_col != '0);
    assign end_pos  = end_pad ? (r_pos + PW'(i_w_eff) - PW'(r_col)) : r_pos;
    assign end_done = (end_pos >= i_count);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_line_left  = r_line_left;
        n_next_skip  = r_next_skip;
        n_copy_left  = r_copy_left;
        n_pos        = r_pos;
        n_col        = r_col;
        n_row        = r_row;
        n_finished   = r_finished;
        n_fault      = r_fault;
        n_recalc     = r_recalc | i_mode.cfg_wr;
        n_pend       = r_pend;
        n_pend_end   = r_pend_end;
        n_pend_issue = r_pend_issue;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out        = r_out;
        pix          = '0;
        issue        = 1'b0;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_pos;

        unique case (r_state)
            BK_RUN: begin
                if (r_recalc) begin
                    // New geometry: rebuild row and column from the position.
                    div_start    = 1'b1;
                    n_recalc     = i_mode.cfg_wr;
                    n_pend_end   = 1'b0;
                    n_pend_issue = 1'b0;
                    n_state      = BK_DIV;
                end else if (i_item_valid && out_free) begin
                    o_pop       = 1'b1;
                    issue       = 1'b1;
                    n_phase     = c_phase;
                    n_line_left = c_line_left;
                    n_next_skip = c_next_skip;
                    n_copy_left = c_copy_left;
                    n_pos       = c_pos;
                    n_col       = c_col;
                    n_row       = c_row;
                    n_finished  = c_finished;
                    n_fault     = c_fault;

                    if (c_finished || (c_fault != FAULT_NONE)) begin
                        issue = 1'b1;
                    end else if (!i_mode.compressed) begin
                        if (in_image) begin
                            pix   = emit_res;
                            n_pos = pos_inc;
                            n_col = col_nxt;
                            n_row = row_nxt;
                        end
                        n_finished = raw_done;
                    end else begin
                        unique case (c_phase)
                            PH_CHUNK: begin
                                n_line_left = ll_dec;
                                if (c_next_skip) begin
                                    n_next_skip = 1'b0;
                                    n_pos       = skip_pos;
                                    if (skip_fast) begin
                                        n_col = CW'(skip_sum);
                                    end else if (skip_one_row) begin
                                        n_col = CW'(skip_sum_w);
                                        n_row = c_row + 1'b1;
                                    end else begin
                                        div_start    = 1'b1;
                                        div_dividend = skip_pos;
                                        issue        = 1'b0;
                                        n_pend_end   = (ll_dec == 8'd0);
                                        n_pend_issue = 1'b1;
                                        n_state      = BK_DIV;
                                    end
                                    if ((skip_fast || skip_one_row) && (ll_dec == 8'd0)) begin
                                        issue   = 1'b0;
                                        n_state = BK_END;
                                    end
                                end else if (copy_over) begin
                                    n_fault = FAULT_OVERRUN;
                                end else begin
                                    n_next_skip = 1'b1;
                                    n_copy_left = b;
                                    if (b != 8'd0) begin
                                        n_phase = PH_COPY;
                                    end else if (ll_dec == 8'd0) begin
                                        issue   = 1'b0;
                                        n_state = BK_END;
                                    end
                                end
                            end
                            PH_COPY: begin
                                pix         = emit_res;
                                n_pos       = pos_inc;
                                n_col       = col_nxt;
                                n_row       = row_nxt;
                                n_copy_left = cl_dec;
                                n_line_left = ll_dec;
                                if (cl_dec == 8'd0) begin
                                    n_phase = PH_CHUNK;
                                    if (ll_dec == 8'd0) begin
                                        issue   = 1'b0;
                                        n_state = BK_END;
                                    end
                                end
                            end
                            default: begin
                                if (i_item.zero) begin
                                    n_fault = FAULT_ZERO_LEN;
                                end else begin
                                    n_line_left = b - 1'b1;
                                    n_next_skip = 1'b1;
                                    n_copy_left = 8'd0;
                                    n_phase     = PH_CHUNK;
                                    if (b == 8'd1) begin
                                        issue   = 1'b0;
                                        n_state = BK_END;
                                    end
                                end
                            end
                        endcase
                    end

                    if (issue) begin
                        n_out_valid = 1'b1;
                        n_out       = pix;
                        n_out.status = status_of(n_fault, n_finished);
                    end else begin
                        n_pend = pix;
                    end
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_col = CW'(div_rem);
                    n_row = div_quo;
                    if (r_pend_end) begin
                        n_state = BK_END;
                    end else if (r_pend_issue) begin
                        n_state = BK_ISSUE;
                    end else begin
                        n_state = BK_RUN;
                    end
                end
            end
            BK_END: begin
                if (out_free) begin
                    n_pos        = end_pos;
                    n_col        = end_pad ? '0 : r_col;
                    n_row        = end_pad ? (r_row + 1'b1) : r_row;
                    n_finished   = end_done;
                    n_phase      = PH_LEN;
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.status = status_of(r_fault, end_done);
                    n_state      = BK_RUN;
                end
            end
            BK_ISSUE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_pend;
                    n_out.status = status_of(r_fault, r_finished);
                    n_state      = BK_RUN;
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_RUN;
            r_phase      <= PH_LEN;
            r_line_left  <= 8'd0;
            r_next_skip  <= 1'b1;
            r_copy_left  <= 8'd0;
            r_pos        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_finished   <= 1'b0;
            r_fault      <= FAULT_NONE;
            r_recalc     <= 1'b0;
            r_pend_end   <= 1'b0;
            r_pend_issue <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_line_left  <= n_line_left;
            r_next_skip  <= n_next_skip;
            r_copy_left  <= n_copy_left;
            r_pos        <= n_pos;
            r_col        <= n_col;
            r_row        <= n_row;
            r_finished   <= n_finished;
            r_fault      <= n_fault;
            r_recalc     <= n_recalc;
            r_pend_end   <= n_pend_end;
            r_pend_issue <= n_pend_issue;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[hw/rtl/srle_checker.sv]
// Port-level checks of the decoder's result channel, bound to the top level.
// Depends on srle_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srle_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_pixel_valid,
    input wire logic [9:0] i_pixel_x,
    input wire logic [9:0] i_pixel_y,
    input wire logic [7:0] i_pixel_value,
    input wire logic [1:0] i_status
);
    import srle_pkg::*;

    `SRLE_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `SRLE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_pixel_valid) && $stable(i_pixel_x) && $stable(i_pixel_y) && $stable(i_pixel_value) && $stable(i_status))
    // A request that writes no pixel reports zero coordinates and value.
    `SRLE_ASSERT_NOW(a_blank_no_pixel, i_clk, i_rst_n, i_out_valid && !i_pixel_valid, i_pixel_x == 10'd0 && i_pixel_y == 10'd0 && i_pixel_value == 8'd0)
    // Faults are raised only by requests that write nothing.
    `SRLE_ASSERT_NOW(a_no_pixel_on_fault, i_clk, i_rst_n, i_out_valid && i_pixel_valid, i_status == ST_BUSY || i_status == ST_DONE)

endmodule

bind sprite_skip_copy_rle_decoder srle_checker u_srle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .i_pixel_valid (o_pixel_valid),
    .i_pixel_x     (o_pixel_x),
    .i_pixel_y     (o_pixel_y),
    .i_pixel_value (o_pixel_value),
    .i_status      (o_status)
);

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the sprite skip/copy run-length decoder: directed
// and random byte streams, a clocked driver and monitor, and a pixel predictor.
// Depends on srle_pkg and sprite_skip_copy_rle_decoder.
`default_nettype none

module testbench;
    import srle_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] data;
    } t_stream_byte;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_start_image = 1'b0;
    logic [7:0]             i_data_byte = 8'd0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_pixel_valid;
    logic [9:0]             o_pixel_x;
    logic [9:0]             o_pixel_y;
    logic [7:0]             o_pixel_value;
    logic [1:0]             o_status;

    sprite_skip_copy_rle_decoder #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_image(i_start_image),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_value(o_pixel_value),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and of the decoder state.
    logic [CFG_DATA_W-1:0] cfg_width = 11'd1;
    logic [CFG_DATA_W-1:0] cfg_height = 11'd1;
    logic                  cfg_compressed = 1'b1;
    logic                  cfg_mirror = 1'b0;
    t_phase                dec_phase;
    logic [7:0]            line_left;
    logic [7:0]            copy_left;
    logic                  next_is_skip;
    logic                  finished;
    logic [STATUS_W-1:0]   fault;
    int unsigned           write_pos;

    t_stream_byte byte_queue[$];
    t_result      expected_pixels[$];
    int           stim_items = 0;
    int           mismatches = 0;
    int           results_checked = 0;

    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic void clear_state();
        dec_phase    = PH_LEN;
        line_left    = 8'd0;
        copy_left    = 8'd0;
        next_is_skip = 1'b1;
        finished     = 1'b0;
        fault        = FAULT_NONE;
        write_pos    = 0;
    endfunction

    // End of a line: pad to the next row, and the image is done once full.
    function automatic void close_line(input int unsigned w, input int unsigned count);
        if (write_pos < count && write_pos % w != 0) write_pos += w - write_pos % w;
        if (write_pos >= count) finished = 1'b1;
        dec_phase = PH_LEN;
    endfunction

    function automatic t_result decode_byte(input logic start, input logic [7:0] b);
        int unsigned w, count, room, px, py;
        logic        emit;
        t_result     r;
        w     = eff_dim(cfg_width, MAX_W);
        count = w * eff_dim(cfg_height, MAX_H);
        emit  = 1'b0;
        px    = 0;
        py    = 0;
        if (start) clear_state();
        if (!finished && fault == FAULT_NONE) begin
            if (!cfg_compressed) begin
                if (write_pos < count) begin
                    emit = 1'b1;
                    px = write_pos % w;
                    py = write_pos / w;
                    write_pos++;
                end
                if (write_pos >= count) finished = 1'b1;
            end else begin
                case (dec_phase)
                    PH_CHUNK: begin
                        line_left = line_left - 8'd1;
                        room = (write_pos < count) ? count - write_pos : 0;
                        if (next_is_skip) begin
                            // A skip that runs past the end parks the position there.
                            if (b >= room) begin
                                if (write_pos < count) write_pos = count;
                            end else begin
                                write_pos += b;
                            end
                            next_is_skip = 1'b0;
                            if (line_left == 0) close_line(w, count);
                        end else if (b > room || b > line_left) begin
                            fault = FAULT_OVERRUN;
                        end else begin
                            next_is_skip = 1'b1;
                            copy_left = b;
                            if (b != 0) dec_phase = PH_COPY;
                            else if (line_left == 0) close_line(w, count);
                        end
                    end
                    PH_COPY: begin
                        emit = 1'b1;
                        px = write_pos % w;
                        py = write_pos / w;
                        write_pos++;
                        copy_left = copy_left - 8'd1;
                        line_left = line_left - 8'd1;
                        if (copy_left == 0) begin
                            dec_phase = PH_CHUNK;
                            if (line_left == 0) close_line(w, count);
                        end
                    end
                    default: begin
                        if (b == 0) begin
                            fault = FAULT_ZERO_LEN;
                        end else begin
                            line_left = b - 8'd1;
                            next_is_skip = 1'b1;
                            copy_left = 8'd0;
                            dec_phase = PH_CHUNK;
                            if (line_left == 0) close_line(w, count);
                        end
                    end
                endcase
            end
        end
        if (emit && cfg_mirror) px = w - 1 - px;
        r.pixel_valid = emit;
        r.pixel_x     = emit ? 10'(px) : 10'd0;
        r.pixel_y     = emit ? 10'(py) : 10'd0;
        r.pixel_value = emit ? b : 8'd0;
        if (fault != FAULT_NONE) r.status = fault;
        else r.status = finished ? ST_DONE : ST_BUSY;
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100) $display("mismatch at result %0d: %s", results_checked, what);
    endtask

    // Request driver.
    int send_gap = 0;
    int send_calm = 0;
    always @(posedge i_clk) begin : drive_requests
        t_stream_byte nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) expected_pixels.push_back(decode_byte(i_start_image, i_data_byte));
            if (send_calm > 0) send_calm--;
            else if ($urandom_range(0, 299) == 0) send_calm = $urandom_range(50, 250);
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                nxt = byte_queue.pop_front();
                i_in_valid <= 1'b1;
                i_start_image <= nxt.start;
                i_data_byte <= nxt.data;
                send_gap = (send_calm > 0) ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result acceptance, with one long hold-off so that the block backs up.
    int hold_left = 0;
    int recv_calm = 0;
    int results_taken = 0;
    bit long_hold_done = 1'b0;
    always @(posedge i_clk) begin : drive_out_ready
        if (i_rst_n && o_out_valid && i_out_ready) results_taken++;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && results_taken >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            i_out_ready <= 1'b0;
        end else if (recv_calm > 0) begin
            recv_calm--;
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 299) == 0) begin
            recv_calm = $urandom_range(50, 250);
            i_out_ready <= 1'b1;
        end else begin
            hold_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            i_out_ready <= (hold_left == 0);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_valid !== want.pixel_valid)
                    report_mismatch($sformatf("pixel_valid %0b, expected %0b",
                                              o_pixel_valid, want.pixel_valid));
                if (o_pixel_x !== want.pixel_x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                              o_pixel_x, want.pixel_x));
                if (o_pixel_y !== want.pixel_y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                              o_pixel_y, want.pixel_y));
                if (o_pixel_value !== want.pixel_value)
                    report_mismatch($sformatf("pixel_value %0d, expected %0d",
                                              o_pixel_value, want.pixel_value));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
            end
            results_checked++;
        end
    end

    task automatic push_byte(input logic start, input logic [7:0] data, input bit counts);
        byte_queue.push_back('{start: start, data: data});
        if (counts) stim_items++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || expected_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:      cfg_width = val;
            CFG_HEIGHT:     cfg_height = val;
            CFG_COMPRESSED: cfg_compressed = val[0];
            default:        cfg_mirror = val[0];
        endcase
        @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim(input int typical_max);
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd2047;
            2:       return 11'd1024;
            3:       return 11'd1;
            default: return 11'($urandom_range(1, typical_max));
        endcase
    endfunction

    // Well-formed lines with random content; a faulty image may end in a zero
    // line length or a copy that overruns the image or the line.
    task automatic gen_coded_image(input bit fresh, input bit faulty);
        int unsigned w, count, pos, room, cmax, row_left;
        int          rest, s, c, made;
        logic [7:0]  line_q[$];
        bit          first, broken;
        w      = eff_dim(cfg_width, MAX_W);
        count  = w * eff_dim(cfg_height, MAX_H);
        pos    = fresh ? 0 : write_pos;
        first  = fresh;
        made   = 0;
        broken = 1'b0;
        while (pos < count && made < 150 && !broken) begin
            line_q = {};
            rest = ($urandom_range(0, 19) == 0) ? 254 : $urandom_range(0, 24);
            if (faulty && $urandom_range(0, 9) == 0) begin
                line_q.push_back(8'd0);
                broken = 1'b1;
            end else begin
                line_q.push_back(8'(rest + 1));
            end
            while (rest > 0 && !broken) begin
                room = (pos < count) ? count - pos : 0;
                row_left = w - pos % w;
                if (row_left > 255) row_left = 255;
                s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, row_left);
                line_q.push_back(8'(s));
                rest--;
                if (s >= room) begin
                    if (pos < count) pos = count;
                end else begin
                    pos += s;
                end
                if (rest > 0) begin
                    room = (pos < count) ? count - pos : 0;
                    cmax = (room < rest - 1) ? room : rest - 1;
                    if (faulty && $urandom_range(0, 9) == 0) begin
                        c = ($urandom_range(0, 1) == 1 && room < 255) ? room + 1 : rest;
                        broken = 1'b1;
                    end else begin
                        c = $urandom_range(0, cmax);
                    end
                    line_q.push_back(8'(c));
                    rest--;
                    if (!broken) begin
                        repeat (c) line_q.push_back(8'($urandom));
                        rest -= c;
                        pos += c;
                    end
                end
            end
            foreach (line_q[k]) push_byte(first && k == 0, line_q[k], 1'b1);
            first = 1'b0;
            made += line_q.size();
            if (!broken && pos < count && pos % w != 0) pos += w - pos % w;
        end
        // Bytes after the end of an image are ignored by the block.
        if (broken || pos >= count)
            repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom), 1'b0);
    endtask

    task automatic gen_raw_image(input bit fresh);
        int unsigned count, pos;
        int          n;
        count = eff_dim(cfg_width, MAX_W) * eff_dim(cfg_height, MAX_H);
        pos = fresh ? 0 : write_pos;
        n = (pos < count) ? count - pos : 0;
        if (n > 64) n = $urandom_range(8, 64);
        for (int k = 0; k < n; k++) push_byte(fresh && k == 0, 8'($urandom), 1'b1);
        repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom), 1'b0);
    endtask

    task automatic gen_noise();
        push_byte(1'b1, 8'($urandom), 1'b1);
        repeat ($urandom_range(1, 16))
            push_byte($urandom_range(0, 7) == 0, 8'($urandom), 1'b1);
    endtask

    initial begin : stimulus
        bit keep_going;
        int kind;
        clear_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, one pixel: zero line length, a copy longer than the
        // line, then a good line that completes the image and an ignored byte.
        push_byte(1'b1, 8'h00, 1'b0);
        push_byte(1'b0, 8'h05, 1'b0);
        push_byte(1'b1, 8'd3, 1'b0);
        push_byte(1'b0, 8'd0, 1'b0);
        push_byte(1'b0, 8'd1, 1'b0);
        push_byte(1'b1, 8'd4, 1'b0);
        push_byte(1'b0, 8'd0, 1'b0);
        push_byte(1'b0, 8'd1, 1'b0);
        push_byte(1'b0, 8'hFF, 1'b0);
        push_byte(1'b0, 8'h00, 1'b0);
        wait_drained();

        // Oversized width saturates, zero height counts as one, mirrored row;
        // then a long skip within the row and a line that completes the image.
        write_reg(CFG_WIDTH, 11'd2047);
        write_reg(CFG_HEIGHT, 11'd0);
        write_reg(CFG_MIRROR, 11'd1);
        push_byte(1'b1, 8'd4, 1'b0);
        push_byte(1'b0, 8'd255, 1'b0);
        push_byte(1'b0, 8'd1, 1'b0);
        push_byte(1'b0, 8'hAA, 1'b0);
        push_byte(1'b1, 8'd3, 1'b0);
        push_byte(1'b0, 8'd255, 1'b0);
        push_byte(1'b0, 8'd0, 1'b0);
        wait_drained();

        // Raw pixels, with the width changed part way through the image.
        write_reg(CFG_WIDTH, 11'd3);
        write_reg(CFG_HEIGHT, 11'd2);
        write_reg(CFG_COMPRESSED, 11'd0);
        write_reg(CFG_MIRROR, 11'd0);
        push_byte(1'b1, 8'h12, 1'b0);
        repeat (3) push_byte(1'b0, 8'($urandom), 1'b0);
        wait_drained();
        write_reg(CFG_WIDTH, 11'd5);
        push_byte(1'b0, 8'h7E, 1'b0);

        stim_items = 0;
        while (stim_items < RANDOM_ITEMS) begin
            wait_drained();
            if ($urandom_range(0, 3) != 0) write_reg(CFG_WIDTH, pick_dim(12));
            if ($urandom_range(0, 3) != 0) write_reg(CFG_HEIGHT, pick_dim(6));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_COMPRESSED, CFG_DATA_W'($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_MIRROR, CFG_DATA_W'($urandom_range(0, 1)));
            // Sometimes carry on with the image already under way.
            keep_going = !finished && fault == FAULT_NONE &&
                         (dec_phase == PH_LEN || !cfg_compressed) &&
                         $urandom_range(0, 3) == 0;
            repeat ($urandom_range(1, 4)) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) gen_noise();
                else if (cfg_compressed) gen_coded_image(!keep_going, kind <= 2);
                else gen_raw_image(!keep_going);
                keep_going = 1'b0;
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
